/* src/tfsn_pkg.sv */
// shared constants, types and sequencer command for the triangle-fold sorter
`default_nettype none

package tfsn_pkg;

    localparam int COUNT  = 64;
    localparam int KEY_W  = 16;
    localparam int IDX_W  = (COUNT > 2) ? $clog2(COUNT) : 1;
    localparam int SIZE_W = IDX_W + 1;

    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [SIZE_W-1:0] t_size;

    // one compare-swap of the network: smaller key goes to a_idx
    typedef struct packed {
        t_idx a_idx;
        t_idx p_idx;
        logic last;
    } t_seq_cmd;

endpackage

`default_nettype wire

/* src/tfsn_key_if.sv */
// input channel carrying one key word
`default_nettype none

interface tfsn_key_if;
    import tfsn_pkg::*;

    logic valid;
    logic ready;
    t_key key;

    modport source (output valid, output key, input ready);
    modport sink (input valid, input key, output ready);
endinterface

`default_nettype wire

/* src/tfsn_res_if.sv */
// output channel carrying one sorted key word and its frame marker
`default_nettype none

interface tfsn_res_if;
    import tfsn_pkg::*;

    logic valid;
    logic ready;
    t_key sorted_key;
    logic last;

    modport source (output valid, output sorted_key, output last, input ready);
    modport sink (input valid, input sorted_key, input last, output ready);
endinterface

`default_nettype wire

/* src/triangle_fold_sorting_network.sv */
// top level of the triangle-fold sorter: key memory, control and output channel
`default_nettype none

// Sorts frames of COUNT (64) unsigned 16-bit keys. Words are taken on i_in one
// per cycle in index order; ready stays low while a frame is being sorted or
// sent. Once the COUNT-th word of a frame is in, a fixed compare-swap network
// runs over the key memory and the keys then leave on o_out in index order,
// with last set on the final one. Each compare-swap passes through S_RD and
// S_CMP, and one that exchanges goes on to S_WR2 (about 1664 compare-swaps
// for 64 keys); each output word is read in S_ORD and held until taken. The
// pace is set by the key memory: one write port, so an exchange needs two
// writes, and a registered read for each pair.
module triangle_fold_sorting_network (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tfsn_key_if.sink   i_in,
    tfsn_res_if.source o_out
);
    import tfsn_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,   // taking key words
        S_RD    = 5'b00010,   // read the pair of the current compare-swap
        S_CMP   = 5'b00100,   // compare, write lower index on exchange
        S_WR2   = 5'b01000,   // write upper index of an exchange
        S_ORD   = 5'b10000    // read next output key
    } t_state;

    // output words are held while o_out waits; uses its own flag since
    // S_ORD and the wait share the same memory read
    t_state   r_state, n_state;
    logic     r_oval,  n_oval;
    t_idx     r_cnt,   n_cnt;     // load count, then output index

    t_key     r_mem [COUNT];
    t_key     r_rd0;
    t_key     r_rd1;

    t_seq_cmd w_cmd;
    logic     w_adv;
    logic     w_swap;
    logic     w_in_acc;
    logic     w_out_acc;

    logic     w_rd_en;
    t_idx     w_raddr0;
    logic     w_we;
    t_idx     w_waddr;
    t_key     w_wdata;

    tfsn_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .o_cmd   (w_cmd)
    );

    // channel side
    assign i_in.ready       = (r_state == S_LOAD);
    assign o_out.valid      = r_oval;
    assign o_out.sorted_key = r_rd0;
    assign o_out.last       = (r_cnt == t_idx'(COUNT - 1));

    assign w_in_acc  = i_in.valid & i_in.ready;
    assign w_out_acc = r_oval & o_out.ready;
    assign w_swap    = (r_rd0 > r_rd1);

    always_comb begin
        n_state  = r_state;
        n_oval   = r_oval;
        n_cnt    = r_cnt;
        w_adv    = 1'b0;
        w_rd_en  = 1'b0;
        w_raddr0 = w_cmd.a_idx;
        w_we     = 1'b0;
        w_waddr  = w_cmd.a_idx;
        w_wdata  = r_rd1;
        case (r_state)
            S_LOAD: begin
                w_waddr = r_cnt;
                w_wdata = i_in.key;
                if (w_in_acc) begin
                    w_we  = 1'b1;
                    n_cnt = r_cnt + t_idx'(1);
                    if (r_cnt == t_idx'(COUNT - 1)) begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                w_rd_en = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_swap) begin
                    // smaller key down to the lower index
                    w_we    = 1'b1;
                    n_state = S_WR2;
                end else begin
                    w_adv   = 1'b1;
                    n_state = w_cmd.last ? S_ORD : S_RD;
                end
            end
            S_WR2: begin
                w_we    = 1'b1;
                w_waddr = w_cmd.p_idx;
                w_wdata = r_rd0;
                w_adv   = 1'b1;
                n_state = w_cmd.last ? S_ORD : S_RD;
            end
            S_ORD: begin
                w_raddr0 = r_cnt;
                if (!r_oval) begin
                    w_rd_en = 1'b1;
                    n_oval  = 1'b1;
                end else if (o_out.ready) begin
                    n_oval = 1'b0;
                    n_cnt  = r_cnt + t_idx'(1);
                    if (r_cnt == t_idx'(COUNT - 1)) begin
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
                n_oval  = 1'b0;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_oval  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
            r_cnt   <= n_cnt;
        end
    end

    // key memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rd0 <= r_mem[w_raddr0];
            r_rd1 <= r_mem[w_cmd.p_idx];
        end
    end

    // every pair of the network has its first index in the lower half
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (w_cmd.a_idx < w_cmd.p_idx))
        else $error("compare-swap pair out of order");

    // no word is taken while results are still going out
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("load overlaps output");

    // the final word of a frame reopens loading
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_out.last) |=> (r_state == S_LOAD && r_cnt == '0))
        else $error("frame end did not return to load");

    // sequencer is back at its start point whenever loading
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (w_cmd.a_idx == '0 && !w_cmd.last))
        else $error("sequencer not at start while loading");

endmodule

`default_nettype wire

/* src/tfsn_seq.sv */
// walks the compare-swap network: limits, blocks in preorder, passes and steps
`default_nettype none

module tfsn_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    output tfsn_pkg::t_seq_cmd     o_cmd
);
    import tfsn_pkg::*;

    t_idx  r_limit, n_limit;
    t_size r_size,  n_size;
    t_idx  r_base,  n_base;
    t_idx  r_step,  n_step;
    t_idx  r_tri,   n_tri;
    logic  r_pass,  n_pass;

    t_size w_half;
    t_idx  w_mask;
    logic  w_last_t;
    t_size w_leaf_sz;
    logic  w_leaf;
    t_size w_next_base;
    logic  w_lim_end;
    logic  w_lim_one;
    t_size w_lowbit;
    t_idx  w_b;
    t_idx  w_c;
    t_idx  w_lo;
    t_idx  w_hi;

    always_comb begin
        w_half      = r_size >> 1;
        w_mask      = w_half[IDX_W-1:0] - t_idx'(1);
        w_last_t    = ({1'b0, r_step} == (w_half - t_size'(1)));
        w_leaf_sz   = ({1'b0, r_limit} < t_size'(2)) ? t_size'(2) : {1'b0, r_limit};
        w_leaf      = (r_size == w_leaf_sz);
        w_next_base = {1'b0, r_base} + r_size;
        w_lim_end   = (w_next_base == t_size'(COUNT));
        w_lim_one   = (r_limit == t_idx'(1));
        // first block of the next subtree is the largest one aligned at its base
        w_lowbit    = w_next_base & (~w_next_base + t_size'(1));

        // mirror and triangular partner
        w_b  = r_base + t_idx'(r_size - t_size'(1) - {1'b0, r_step});
        w_c  = r_base + w_half[IDX_W-1:0] + r_tri;
        w_lo = (w_b < w_c) ? w_b : w_c;
        w_hi = (w_b < w_c) ? w_c : w_b;

        o_cmd.a_idx = r_base + r_step;
        o_cmd.p_idx = r_pass ? w_lo : w_hi;
        o_cmd.last  = r_pass & w_last_t & w_leaf & w_lim_end & w_lim_one;
    end

    always_comb begin
        n_limit = r_limit;
        n_size  = r_size;
        n_base  = r_base;
        n_step  = r_step;
        n_tri   = r_tri;
        n_pass  = r_pass;
        if (i_adv) begin
            if (!w_last_t) begin
                n_step = r_step + t_idx'(1);
                n_tri  = (r_tri + r_step + t_idx'(1)) & w_mask;
            end else if (!r_pass) begin
                n_pass = 1'b1;
                n_step = '0;
                n_tri  = '0;
            end else begin
                n_pass = 1'b0;
                n_step = '0;
                n_tri  = '0;
                if (!w_leaf) begin
                    n_size = w_half;
                end else if (!w_lim_end) begin
                    n_base = w_next_base[IDX_W-1:0];
                    n_size = w_lowbit;
                end else begin
                    // limit finished: next limit, or back to the start state
                    n_base  = '0;
                    n_size  = t_size'(COUNT);
                    n_limit = w_lim_one ? t_idx'(COUNT / 2) : (r_limit >> 1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= t_idx'(COUNT / 2);
            r_size  <= t_size'(COUNT);
            r_base  <= '0;
            r_step  <= '0;
            r_tri   <= '0;
            r_pass  <= 1'b0;
        end else begin
            r_limit <= n_limit;
            r_size  <= n_size;
            r_base  <= n_base;
            r_step  <= n_step;
            r_tri   <= n_tri;
            r_pass  <= n_pass;
        end
    end

endmodule

`default_nettype wire
